// ===== hdl/aes_pkg.sv =====
// Package: shared types, S-box tables and GF(2^8) helpers for the AES-128 core.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundW    = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_STEP
  } key_state_e;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic             load;      // take the input block, add the first round key
    logic             step;      // run one round
    logic             last;      // this round is the final one
    logic             decrypt;
    logic [RoundW-1:0] round;    // round key index used by this step
  } dp_cmd_t;

  function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[a];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/aes_if.sv =====
// Interfaces: valid/ready channels for blocks, results and key writes.
`timescale 1ns / 1ps
`default_nettype none
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, command, block_high, block_low, input ready);
  modport sink (input valid, command, block_high, block_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/aes128_block_cipher.sv =====
// Top level: AES-128 block cipher with key schedule, controller and round datapath.
//
// Channels: in (command, 128-bit block as two 64-bit halves) and out (result halves),
// both valid/ready; cfg writes key_high (index 0) or key_low (index 1).
// Each key write restarts the key expansion: a load then one round key per cycle,
// during which no item is accepted. Reset loads the zero key and expands it too.
// An item starts with the initial key addition at accept, then ten rounds, one per
// cycle through the single round unit; the result then sits in the state register
// with out valid. A new item is accepted in the same cycle that the result is taken,
// so while the receiver keeps up a new item starts as the last result leaves.
// When the receiver stalls the result holds and no new item is taken.
// Decryption uses the straightforward inverse cipher with round keys in reverse.
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_cipher (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aes_in_if.sink    in_i,
  aes_out_if.source out_o,
  aes_cfg_if.sink   cfg_i
);

  aes_pkg::dp_cmd_t cmd;
  logic [127:0] rkey, st;
  logic key_busy;

  assign cfg_i.ready = 1'b1;

  aes_key_sched u_key (
    .clk_i, .rst_ni,
    .wr_en_i(cfg_i.valid), .wr_idx_i(cfg_i.index), .wr_data_i(cfg_i.data),
    .rd_round_i(cmd.round), .rd_key_o(rkey), .busy_o(key_busy)
  );

  aes_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_cmd_i(in_i.command), .in_ready_o(in_i.ready),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .key_busy_i(key_busy), .cmd_o(cmd)
  );

  aes_datapath u_dp (
    .clk_i, .cmd_i(cmd), .in_block_i({in_i.block_high, in_i.block_low}),
    .round_key_i(rkey), .state_o(st)
  );

  assign out_o.result_high = st[127:64];
  assign out_o.result_low  = st[63:0];

endmodule
`default_nettype wire

// ===== hdl/aes_key_sched.sv =====
// Key schedule: key registers and the 44-word round key store, expanded one round a cycle.
`timescale 1ns / 1ps
`default_nettype none
module aes_key_sched (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_en_i,
  input  wire logic [0:0]  wr_idx_i,
  input  wire logic [63:0] wr_data_i,
  input  wire logic [aes_pkg::RoundW-1:0] rd_round_i,
  output logic [127:0]     rd_key_o,
  output logic             busy_o
);

  logic [63:0]  key_high_q, key_low_q;
  logic [127:0] rk_q [aes_pkg::NumRounds+1];
  logic [127:0] cur_q, nxt;
  logic [aes_pkg::RoundW-1:0] cnt_q;
  aes_pkg::key_state_e state_q, state_d;
  logic [31:0] t, w0, w1, w2, w3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        aes_pkg::REG_KEY_HIGH: key_high_q <= wr_data_i;
        aes_pkg::REG_KEY_LOW:  key_low_q  <= wr_data_i;
        default: ;
      endcase
    end
  end

  // reset also starts an expansion (of the zero key)
  // a write during the load cycle reloads, since the load saw the old key
  always_comb begin
    state_d = state_q;
    case (state_q)
      aes_pkg::KS_IDLE: if (wr_en_i) state_d = aes_pkg::KS_LOAD;
      aes_pkg::KS_LOAD: begin
        if (wr_en_i) state_d = aes_pkg::KS_LOAD;
        else state_d = aes_pkg::KS_STEP;
      end
      aes_pkg::KS_STEP: begin
        if (wr_en_i) state_d = aes_pkg::KS_LOAD;
        else if (cnt_q == aes_pkg::RoundW'(aes_pkg::NumRounds)) state_d = aes_pkg::KS_IDLE;
      end
      default: state_d = aes_pkg::KS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aes_pkg::KS_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == aes_pkg::KS_LOAD) cnt_q <= 4'd1;
      else if (state_q == aes_pkg::KS_STEP) cnt_q <= cnt_q + 4'd1;
    end
  end

  always_comb begin
    t  = {cur_q[23:0], cur_q[31:24]};
    t  = aes_pkg::sub_word(t) ^ {aes_pkg::rcon(cnt_q), 24'h0};
    w0 = cur_q[127:96] ^ t;
    w1 = cur_q[95:64] ^ w0;
    w2 = cur_q[63:32] ^ w1;
    w3 = cur_q[31:0] ^ w2;
    nxt = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == aes_pkg::KS_LOAD) begin
      cur_q    <= {key_high_q, key_low_q};
      rk_q[0]  <= {key_high_q, key_low_q};
    end else if (state_q == aes_pkg::KS_STEP) begin
      cur_q        <= nxt;
      rk_q[cnt_q]  <= nxt;
    end
  end

  assign rd_key_o = rk_q[rd_round_i];
  assign busy_o   = (state_q != aes_pkg::KS_IDLE);

endmodule
`default_nettype wire

// ===== hdl/aes_datapath.sv =====
// Datapath: state register and one round of the forward or inverse cipher per cycle.
`timescale 1ns / 1ps
`default_nettype none
module aes_datapath (
  input  wire logic             clk_i,
  input  wire aes_pkg::dp_cmd_t cmd_i,
  input  wire logic [127:0]     in_block_i,
  input  wire logic [127:0]     round_key_i,
  output logic [127:0]          state_o
);

  logic [127:0] st_q, st_d, sr, sb, mc, fwd, inv;

  function automatic logic [7:0] bget(input logic [127:0] s, input int c, input int r);
    return s[127 - 32*c - 8*r -: 8];
  endfunction

  function automatic logic [31:0] mix_fwd(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    return {aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3,
            aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3)};
  endfunction

  // inverse mix as a pre-multiply by {05,00,04,00}-style step then forward mix
  function automatic logic [31:0] mix_inv(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    u = aes_pkg::xtime(aes_pkg::xtime(a0 ^ a2));
    v = aes_pkg::xtime(aes_pkg::xtime(a1 ^ a3));
    return mix_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  always_comb begin
    // forward: SubBytes, ShiftRows, MixColumns (not last), AddRoundKey
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[127 - 32*c - 8*r -: 8] = aes_pkg::fwd_sbox(bget(st_q, (c + r) % 4, r));
      end
    end
    for (int c = 0; c < 4; c++) mc[127 - 32*c -: 32] = mix_fwd(sb[127 - 32*c -: 32]);
    fwd = (cmd_i.last ? sb : mc) ^ round_key_i;
    // inverse: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns (not last)
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127 - 32*c - 8*r -: 8] = aes_pkg::inv_sbox(bget(st_q, (c + 3*r) % 4, r));
      end
    end
    sr = sr ^ round_key_i;
    for (int c = 0; c < 4; c++) inv[127 - 32*c -: 32] = mix_inv(sr[127 - 32*c -: 32]);
    if (cmd_i.last) inv = sr;
    if (cmd_i.load) st_d = in_block_i ^ round_key_i;
    else if (cmd_i.step) st_d = cmd_i.decrypt ? inv : fwd;
    else st_d = st_q;
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign state_o = st_q;

endmodule
`default_nettype wire

// ===== hdl/aes_ctrl.sv =====
// Controller: sequences the initial key addition, ten rounds and the result handshake.
`timescale 1ns / 1ps
`default_nettype none
module aes_ctrl (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  in_cmd_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire logic  key_busy_i,
  output aes_pkg::dp_cmd_t cmd_o
);

  aes_pkg::ctrl_state_e state_q, state_d;
  logic [aes_pkg::RoundW-1:0] rnd_q;
  logic dec_q;
  logic accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      aes_pkg::ST_IDLE: if (accept) state_d = aes_pkg::ST_RUN;
      aes_pkg::ST_RUN:  if (rnd_q == aes_pkg::RoundW'(aes_pkg::NumRounds)) state_d = aes_pkg::ST_OUT;
      aes_pkg::ST_OUT: begin
        if (out_ready_i) state_d = accept ? aes_pkg::ST_RUN : aes_pkg::ST_IDLE;
      end
      default: state_d = aes_pkg::ST_IDLE;
    endcase
  end

  // rnd_q holds the number of the round in progress; datapath key index follows direction
  always_comb begin
    in_ready_o  = !key_busy_i && (state_q == aes_pkg::ST_IDLE ||
                  (state_q == aes_pkg::ST_OUT && out_ready_i));
    out_valid_o = (state_q == aes_pkg::ST_OUT);
    cmd_o.load    = accept;
    cmd_o.step    = (state_q == aes_pkg::ST_RUN);
    cmd_o.last    = (rnd_q == aes_pkg::RoundW'(aes_pkg::NumRounds));
    cmd_o.decrypt = dec_q;
    if (accept) begin
      cmd_o.round = (in_cmd_i == aes_pkg::CMD_DECRYPT) ?
                    aes_pkg::RoundW'(aes_pkg::NumRounds) : '0;
    end else begin
      cmd_o.round = dec_q ? aes_pkg::RoundW'(aes_pkg::NumRounds) - rnd_q : rnd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aes_pkg::ST_IDLE;
      rnd_q   <= '0;
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        rnd_q <= 4'd1;
        dec_q <= in_cmd_i;
      end else if (state_q == aes_pkg::ST_RUN) begin
        rnd_q <= rnd_q + 4'd1;
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_busy_i |-> !in_ready_o) else $error("item taken during key expansion");
  a_run_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aes_pkg::ST_RUN && rnd_q == 4'd10) |=> state_q == aes_pkg::ST_OUT)
    else $error("last round did not finish");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");

endmodule
`default_nettype wire
